// ----- design/assert_macros.svh -----
// assertion macros used by the core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gshe_pkg.sv -----
// shared types, codes and constants of the gamepad serial host engine
`timescale 1ns / 1ps

package gshe_pkg;

  // default number of bytes in a read frame
  localparam int unsigned DefFrameBytes = 9;

  // link command bytes
  localparam logic [7:0] CMD_START   = 8'h01;
  localparam logic [7:0] CMD_POLL    = 8'h42;
  localparam logic [7:0] CMD_CONFIG  = 8'h43;
  localparam logic [7:0] CMD_ANALOG  = 8'h44;
  localparam logic [7:0] CMD_VIB_MAP = 8'h4D;
  localparam logic [7:0] CMD_FILL    = 8'h5A;
  localparam logic [7:0] CMD_LOCK    = 8'h03;
  localparam logic [7:0] CMD_ONE     = 8'h01;
  localparam logic [7:0] CMD_ZERO    = 8'h00;

  // mode byte reported by a pad in analog (red light) mode
  localparam logic [7:0] MODE_ANALOG = 8'h73;

  // host opcodes
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_READ       = 4'd1,
    OP_POLL       = 4'd2,
    OP_ENTER      = 4'd3,
    OP_ANALOG     = 4'd4,
    OP_EXIT       = 4'd5,
    OP_VIBRATE    = 4'd6,
    OP_VIB_ENABLE = 4'd7,
    OP_MODE_CHECK = 4'd8
  } opcode_e;

  // link sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEAD = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_GAP  = 3'd4,
    PH_TAIL = 3'd5
  } phase_e;

  // pin and busy levels after one tick
  typedef struct packed {
    logic select_n;
    logic clock_out;
    logic command_out;
    logic busy;
  } link_status_t;

  // decoded pad answer
  typedef struct packed {
    logic [7:0]  mode_id;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [4:0]  key_index;
    logic        analog_mode;
  } pad_report_t;

  // gap after select falls
  function automatic logic op_lead(opcode_e op);
    return (op != OP_READ) && (op != OP_ANALOG) && (op != OP_MODE_CHECK);
  endfunction

  // gap after select rises
  function automatic logic op_tail(opcode_e op);
    return (op != OP_READ) && (op != OP_MODE_CHECK);
  endfunction

endpackage

// ----- design/gshe_link_fsm.sv -----
// tick sequencer: select, clock and command pins plus the receive store
`timescale 1ns / 1ps

module gshe_link_fsm import gshe_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DefFrameBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [3:0]   opcode_i,
  input  logic [7:0]   motor_small_i,
  input  logic [7:0]   motor_large_i,
  input  logic         data_in_i,
  input  logic [9:0]   hp_ticks_i,
  input  logic [11:0]  gap_ticks_i,
  output link_status_t status_o,
  output logic [7:0]   store_o [FRAME_BYTES]
);

  localparam int unsigned MaxBytes = (FRAME_BYTES > 9) ? FRAME_BYTES : 9;
  localparam int unsigned PosW     = $clog2(MaxBytes + 1);

  typedef logic [PosW-1:0] pos_t;

  phase_e      phase_q, phase_d;
  opcode_e     op_q, op_d;
  pos_t        pos_q, pos_d;
  logic [2:0]  bit_q, bit_d;
  logic [11:0] delay_q, delay_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  store_q [FRAME_BYTES];
  logic [7:0]  store_d [FRAME_BYTES];
  logic [7:0]  motor_q [2];
  logic [7:0]  motor_d [2];

  logic        valid_op;
  logic        clear_all;
  logic        set_bit;
  logic        begin_byte;
  logic [11:0] hp_len;
  logic [11:0] gap_len;
  pos_t        tgt_cur;
  pos_t        tgt_new;

  // command byte sent at a given frame position
  function automatic logic [7:0] cmd_byte(opcode_e op, pos_t pos,
                                          logic [7:0] m_small, logic [7:0] m_large);
    logic [7:0] b;
    b = CMD_ZERO;
    if (pos == pos_t'(0)) begin
      b = CMD_START;
    end else if (pos == pos_t'(1)) begin
      unique case (op)
        OP_ENTER, OP_EXIT: b = CMD_CONFIG;
        OP_ANALOG:         b = CMD_ANALOG;
        OP_VIB_ENABLE:     b = CMD_VIB_MAP;
        default:           b = CMD_POLL;
      endcase
    end else begin
      unique case (op)
        OP_ENTER:      b = (pos == pos_t'(3)) ? CMD_ONE : CMD_ZERO;
        OP_ANALOG:     b = (pos == pos_t'(3)) ? CMD_ONE :
                           ((pos == pos_t'(4)) ? CMD_LOCK : CMD_ZERO);
        OP_EXIT:       b = (pos >= pos_t'(4)) ? CMD_FILL : CMD_ZERO;
        OP_VIBRATE:    b = (pos == pos_t'(3)) ? m_small :
                           ((pos == pos_t'(4)) ? m_large : CMD_ZERO);
        OP_VIB_ENABLE: b = (pos == pos_t'(4)) ? CMD_ONE : CMD_ZERO;
        default:       b = CMD_ZERO;
      endcase
    end
    return b;
  endfunction

  // bytes in the frame of an opcode
  function automatic pos_t op_bytes(opcode_e op);
    pos_t n;
    unique case (op)
      OP_READ:                n = pos_t'(FRAME_BYTES);
      OP_POLL, OP_VIB_ENABLE: n = pos_t'(5);
      OP_MODE_CHECK:          n = pos_t'(2);
      default:                n = pos_t'(9);
    endcase
    return n;
  endfunction

  // store entry that takes the answer byte
  function automatic pos_t target(opcode_e op, pos_t pos);
    pos_t t;
    if ((op == OP_READ) && (pos >= pos_t'(2)) && (pos < pos_t'(FRAME_BYTES))) begin
      t = pos;
    end else begin
      t = pos_t'(1);
    end
    return t;
  endfunction

  // zero delay registers count as one tick
  assign hp_len   = (hp_ticks_i == 10'd0) ? 12'd1 : {2'b00, hp_ticks_i};
  assign gap_len  = (gap_ticks_i == 12'd0) ? 12'd1 : gap_ticks_i;
  assign valid_op = (opcode_i >= OP_READ) && (opcode_i <= OP_MODE_CHECK);

  // next state of the sequencer and the store
  always_comb begin
    phase_d    = phase_q;
    op_d       = op_q;
    pos_d      = pos_q;
    bit_d      = bit_q;
    delay_d    = delay_q;
    shift_d    = shift_q;
    motor_d    = motor_q;
    clear_all  = 1'b0;
    set_bit    = 1'b0;
    begin_byte = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (valid_op) begin
          op_d  = opcode_e'(opcode_i);
          pos_d = '0;
          if (op_d == OP_VIBRATE) begin
            motor_d[0] = motor_small_i;
            motor_d[1] = motor_large_i;
          end
          clear_all = (op_d == OP_READ);
          if (op_lead(op_d)) begin
            phase_d = PH_LEAD;
            delay_d = gap_len;
          end else begin
            begin_byte = 1'b1;
          end
        end
      end
      PH_LEAD: begin
        if (delay_q > 12'd1) begin
          delay_d = delay_q - 12'd1;
        end else begin
          begin_byte = 1'b1;
        end
      end
      PH_HIGH: begin
        if (delay_q > 12'd1) begin
          delay_d = delay_q - 12'd1;
        end else begin
          phase_d = PH_LOW;
          delay_d = hp_len;
        end
      end
      PH_LOW: begin
        if (delay_q > 12'd1) begin
          delay_d = delay_q - 12'd1;
        end else begin
          set_bit = data_in_i;
          if (bit_q == 3'd7) begin
            phase_d = PH_GAP;
            delay_d = gap_len;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PH_HIGH;
            delay_d = hp_len;
          end
        end
      end
      PH_GAP: begin
        if (delay_q > 12'd1) begin
          delay_d = delay_q - 12'd1;
        end else begin
          pos_d = pos_q + pos_t'(1);
          if (pos_d < op_bytes(op_q)) begin
            begin_byte = 1'b1;
          end else if (op_tail(op_q)) begin
            phase_d = PH_TAIL;
            delay_d = gap_len;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_TAIL: begin
        if (delay_q > 12'd1) begin
          delay_d = delay_q - 12'd1;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // start of a byte: load the shifter and arm the high phase
    if (begin_byte) begin
      shift_d = cmd_byte(op_d, pos_d, motor_d[0], motor_d[1]);
      bit_d   = 3'd0;
      phase_d = PH_HIGH;
      delay_d = hp_len;
    end

    tgt_cur = target(op_q, pos_q);
    tgt_new = target(op_d, pos_d);

    // each entry: frame clear, sampled bit, clear at byte start
    for (int e = 0; e < int'(FRAME_BYTES); e++) begin
      store_d[e] = store_q[e];
      if (clear_all) begin
        store_d[e] = 8'h00;
      end
      if (set_bit && (tgt_cur == pos_t'(e))) begin
        store_d[e][bit_q] = 1'b1;
      end
      if (begin_byte && (tgt_new == pos_t'(e))) begin
        store_d[e] = 8'h00;
      end
    end
  end

  // state registers, advanced once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      pos_q   <= '0;
      bit_q   <= 3'd0;
      delay_q <= 12'd0;
      shift_q <= 8'h00;
      for (int e = 0; e < int'(FRAME_BYTES); e++) begin
        store_q[e] <= 8'h00;
      end
      motor_q[0] <= 8'h00;
      motor_q[1] <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      pos_q   <= pos_d;
      bit_q   <= bit_d;
      delay_q <= delay_d;
      shift_q <= shift_d;
      store_q <= store_d;
      motor_q <= motor_d;
    end
  end

  // pin levels after this tick
  always_comb begin
    status_o.select_n    = (phase_d == PH_IDLE) || (phase_d == PH_TAIL);
    status_o.clock_out   = (phase_d != PH_LOW);
    status_o.command_out = ((phase_d == PH_HIGH) || (phase_d == PH_LOW)) ? shift_d[bit_d]
                                                                        : 1'b0;
    status_o.busy        = (phase_d != PH_IDLE);
  end

  assign store_o = store_d;

endmodule

// ----- design/gshe_decode.sv -----
// decoding of the receive store into the pad report
`timescale 1ns / 1ps

module gshe_decode import gshe_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DefFrameBytes
) (
  input  logic [7:0]  store_i [FRAME_BYTES],
  output pad_report_t report_o
);

  logic [7:0]  view [9];
  logic [15:0] buttons;
  logic [4:0]  key;

  // entries past the frame read as zero
  for (genvar gi = 0; gi < 9; gi++) begin : g_view
    if (gi < FRAME_BYTES) begin : g_live
      assign view[gi] = store_i[gi];
    end else begin : g_absent
      assign view[gi] = 8'h00;
    end
  end

  assign buttons = {view[4], view[3]};

  // lowest pressed button, buttons are active low
  always_comb begin
    key = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (!buttons[i]) begin
        key = 5'(i + 1);
      end
    end
  end

  always_comb begin
    report_o.mode_id     = view[1];
    report_o.buttons     = buttons;
    report_o.right_x     = view[5];
    report_o.right_y     = view[6];
    report_o.left_x      = view[7];
    report_o.left_y      = view[8];
    report_o.key_index   = key;
    report_o.analog_mode = (view[1] == MODE_ANALOG);
  end

endmodule

// ----- design/gamepad_serial_host_engine_core.sv -----
// top level of the gamepad serial host engine: stream ports, registers, result stage
// a result is presented in the cycle after its tick item is accepted
// throughput: one item per cycle; the output register takes a new result while
// the previous one is being taken, so only output backpressure stalls input
// reset (rst_ni low, asynchronous): sequencer idle, receive store and motor
// bytes zero, half period 5 and gap 16 ticks, no result pending
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_serial_host_engine_core import gshe_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DefFrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] motor_small, [15:8] motor_large, [16] data_in, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [3:0] opcode
  input  logic [3:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] select_n, [1] clock_out, [2] command_out, [3] busy_res, [11:4] mode_id,
  // [27:12] buttons, [35:28] right_x, [43:36] right_y, [51:44] left_x,
  // [59:52] left_y, [64:60] key_index, [65] analog_mode, [71:66] zero
  output logic [71:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_GAP         = 1'b1;

  logic         accept;
  logic         cfg_write;
  logic [9:0]   hp_q;
  logic [11:0]  gap_q;
  logic         out_valid_q, out_valid_d;
  link_status_t status;
  link_status_t status_q;
  pad_report_t  report;
  pad_report_t  report_q;
  logic [7:0]   store [FRAME_BYTES];

  // config register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q  <= 10'd5;
      gap_q <= 12'd16;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_HALF_PERIOD: hp_q  <= pwdata[9:0];
        REG_GAP:         gap_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF_PERIOD: prdata = {22'd0, hp_q};
      REG_GAP:         prdata = {20'd0, gap_q};
      default:         prdata = 32'd0;
    endcase
  end

  // input taken whenever the result slot is free or being emptied
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gshe_link_fsm #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_link (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (s_axis_tuser),
    .motor_small_i(s_axis_tdata[7:0]),
    .motor_large_i(s_axis_tdata[15:8]),
    .data_in_i    (s_axis_tdata[16]),
    .hp_ticks_i   (hp_q),
    .gap_ticks_i  (gap_q),
    .status_o     (status),
    .store_o      (store)
  );

  gshe_decode #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_decode (
    .store_i (store),
    .report_o(report)
  );

  // result register
  assign out_valid_d = accept ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      report_q <= report;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, report_q.analog_mode, report_q.key_index,
                          report_q.left_y, report_q.left_x, report_q.right_y,
                          report_q.right_x, report_q.buttons, report_q.mode_id,
                          status_q.busy, status_q.command_out, status_q.clock_out,
                          status_q.select_n};

  // select stays high whenever no transaction runs
  `ASSERT_IMPLY(a_idle_deselect, clk_i, rst_ni, out_valid_q && !status_q.busy, status_q.select_n, "select low while idle")
  // clock low phase only inside a transaction
  `ASSERT_IMPLY(a_clock_busy, clk_i, rst_ni, out_valid_q && !status_q.clock_out, status_q.busy && !status_q.select_n, "clock low outside a transaction")
  // every accepted item leaves a result
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, out_valid_q, "accepted item gave no result")

endmodule
